/* sv/lsps_pkg.sv */
// package for the status led pattern sequencer
// types and codes shared by all modules, and the blink pattern table; no dependencies
`default_nettype none

package lsps_pkg;

  localparam int unsigned LedCount    = 3;
  localparam int unsigned PatternBits = 16;
  localparam int unsigned SeqCount    = 3;
  localparam int unsigned NumCodes    = 11;
  localparam int unsigned CodeW       = 4;
  localparam int unsigned CountW      = 5;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 5;

  localparam logic [CodeW-1:0] CODE_INVALID = 4'd0;
  localparam logic [CodeW-1:0] CODE_AUTO    = 4'd1;
  localparam logic [CodeW-1:0] CODE_RUN     = 4'd3;
  localparam logic [CodeW-1:0] CODE_LAST    = 4'd10;

  localparam logic [CfgIdxW-1:0] CFG_LED_INVERT     = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESENCE_TICKS = 1'd1;

  localparam logic [2:0]        LED_INVERT_RESET     = 3'd6;
  localparam logic [CountW-1:0] PRESENCE_TICKS_RESET = 5'd15;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WINK  = 2'd1,
    FUNC_CHECK = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef logic [SeqCount-1:0][PatternBits-1:0] pattern_set_t;

  typedef struct packed {
    logic [NumCodes-1:0] request_mask;
    logic [CodeW-1:0]    shown_code;
    logic [CodeW-1:0]    last_checked;
    logic [CodeW-1:0]    presence_latch;
    logic [CountW-1:0]   tick_count;
    pattern_set_t        shift_value;
    pattern_set_t        reload_value;
    logic                wake_pending;
    logic                parked;
    logic [2:0]          led_latch;
  } state_t;

  typedef struct packed {
    logic [2:0]        led_invert_mask;
    logic [CountW-1:0] presence_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       led_levels;
    logic [CodeW-1:0] active_code;
    logic             present_ok;
  } result_t;

  localparam state_t STATE_RESET = '{
    request_mask:   '0,
    shown_code:     CODE_INVALID,
    last_checked:   CODE_INVALID,
    presence_latch: CODE_INVALID,
    tick_count:     '0,
    shift_value:    '0,
    reload_value:   '0,
    wake_pending:   1'b1,
    parked:         1'b0,
    led_latch:      '0
  };

  // per-code patterns, sequencer 0 in the low slot
  function automatic pattern_set_t pattern_of(input logic [CodeW-1:0] code);
    pattern_set_t p;
    p = '0;
    case (code)
      4'd0:    p[1] = 16'h0001;
      4'd1:    p[1] = 16'h0001;
      4'd2:    begin
        p[0] = 16'h000C;
        p[1] = 16'h000A;
        p[2] = 16'h0009;
      end
      4'd4:    p[1] = 16'h0801;
      4'd5:    p[1] = 16'h0805;
      4'd6:    p[1] = 16'h0855;
      4'd7:    p[1] = 16'h0955;
      4'd8:    p[1] = 16'h0003;
      4'd9:    p[0] = 16'h001E;
      4'd10:   p[0] = 16'h0006;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* sv/lsps_if.sv */
// request channels of the status led pattern sequencer
// input and result interfaces with valid/ready; depends on lsps_pkg
`default_nettype none

interface lsps_in_if
  import lsps_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [CodeW-1:0] status_code;

  modport source (output valid, output func, output status_code, input ready);
  modport sink (input valid, input func, input status_code, output ready);
endinterface

interface lsps_out_if
  import lsps_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [2:0]       led_levels;
  logic [CodeW-1:0] active_code;
  logic             present_ok;

  modport source (output valid, output led_levels, output active_code,
                  output present_ok, input ready);
  modport sink (input valid, input led_levels, input active_code,
                input present_ok, output ready);
endinterface

`default_nettype wire

/* sv/lsps_step.sv */
// next-state and result logic for one request (tick, wink or presence check)
// purely combinational; depends on lsps_pkg
`default_nettype none

module lsps_step
  import lsps_pkg::*;
(
  input  state_t           state_i,
  input  cfg_t             cfg_i,
  input  logic [1:0]       func_i,
  input  logic [CodeW-1:0] code_i,
  output state_t           state_o,
  output result_t          result_o
);

  func_e             func;
  logic [CodeW-1:0]  next_code;
  logic              changed;
  pattern_set_t      pat;
  pattern_set_t      shift_mid;
  pattern_set_t      reload_mid;
  logic [CountW-1:0] count_mid;
  logic [CountW-1:0] count_inc;
  logic [2:0]        leds;
  logic [PatternBits-1:0] shifted;
  logic [CodeW-1:0]  wink_code;
  logic              in_range;
  logic              ok;

  assign func = func_e'(func_i);

  // priority encode of pending requests, empty mask shows as invalid
  always_comb begin
    next_code = CODE_INVALID;
    for (int c = 0; c < NumCodes; c++) begin
      if (state_i.request_mask[c]) begin
        next_code = CodeW'(c);
      end
    end
  end

  assign changed   = next_code != state_i.shown_code;
  assign pat       = pattern_of(next_code);
  assign count_mid = changed ? '0 : state_i.tick_count;
  assign count_inc = count_mid + CountW'(1);

  always_comb begin
    for (int i = 0; i < SeqCount; i++) begin
      if (changed && (pat[i] != state_i.reload_value[i])) begin
        reload_mid[i] = pat[i];
        shift_mid[i]  = '0;
      end else begin
        reload_mid[i] = state_i.reload_value[i];
        shift_mid[i]  = state_i.shift_value[i];
      end
    end
  end

  always_comb begin
    leds = '0;
    for (int i = 0; i < LedCount; i++) begin
      leds[i] = shift_mid[i][0] ^ cfg_i.led_invert_mask[i];
    end
  end

  assign wink_code = (code_i == CODE_AUTO) ? state_i.last_checked : code_i;
  assign in_range  = code_i <= CODE_LAST;

  always_comb begin
    state_o = state_i;
    ok      = 1'b0;
    shifted = '0;
    case (func)
      FUNC_TICK: begin
        if (!state_i.parked) begin
          state_o.shown_code   = next_code;
          state_o.reload_value = reload_mid;
          state_o.led_latch    = leds;
          state_o.tick_count   = count_mid;
          if (count_mid < cfg_i.presence_ticks) begin
            state_o.tick_count = count_inc;
            if (count_inc == cfg_i.presence_ticks) begin
              state_o.presence_latch = next_code;
            end
          end
          for (int i = 0; i < SeqCount; i++) begin
            shifted = shift_mid[i] >> 1;
            if (shifted <= PatternBits'(1)) begin
              state_o.shift_value[i] = reload_mid[i];
            end else begin
              state_o.shift_value[i] = shifted;
            end
          end
          if (next_code == CODE_RUN) begin
            if (state_i.wake_pending) begin
              state_o.wake_pending = 1'b0;
            end else begin
              state_o.parked = 1'b1;
            end
          end
        end
      end
      FUNC_WINK: begin
        if (wink_code <= CODE_LAST) begin
          state_o.request_mask[wink_code] = 1'b1;
        end
        if (state_i.parked) begin
          state_o.parked = 1'b0;
        end else begin
          state_o.wake_pending = 1'b1;
        end
      end
      FUNC_CHECK: begin
        state_o.last_checked = code_i;
        if (state_i.presence_latch == code_i) begin
          ok                     = 1'b1;
          state_o.presence_latch = CODE_INVALID;
          if (in_range) begin
            state_o.request_mask[code_i] = 1'b0;
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

  assign result_o.led_levels  = state_o.led_latch;
  assign result_o.active_code = state_o.shown_code;
  assign result_o.present_ok  = ok;

endmodule

`default_nettype wire

/* sv/led_status_pattern_sequencer_core.sv */
// Status LED pattern sequencer: takes one request per clock (tick, wink or presence
// check) while the result side keeps up, and returns one result for each. A request is
// registered at the input, worked through the combinational step logic and held in the
// result register, so the sustained rate is one request per cycle, set by that step
// logic. A result that waits holds off the step logic: the input slot takes one more
// request and the input then stalls until the result is taken.
// Configuration (led invert mask, presence ticks) is written through the plain port.
// depends on lsps_pkg, lsps_if and lsps_step
`default_nettype none

module led_status_pattern_sequencer_core
  import lsps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  lsps_in_if.sink             in_s,
  lsps_out_if.source          out_s,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t             cfg_q, cfg_d;
  state_t           state_q, state_next;
  result_t          result_d, result_q;
  logic             in_v_q, in_v_d;
  logic [1:0]       func_q;
  logic [CodeW-1:0] code_q;
  logic             out_v_q, out_v_d;
  logic             adv;
  logic             take;

  assign adv      = in_v_q && (!out_v_q || out_s.ready);
  assign in_s.ready = !in_v_q || adv;
  assign take     = in_s.valid && in_s.ready;
  assign in_v_d   = take ? 1'b1 : (adv ? 1'b0 : in_v_q);
  assign out_v_d  = adv ? 1'b1 : (out_s.ready ? 1'b0 : out_v_q);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LED_INVERT:     cfg_d.led_invert_mask = cfg_data_i[2:0];
        CFG_PRESENCE_TICKS: cfg_d.presence_ticks  = cfg_data_i[CountW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  lsps_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .func_i   (func_q),
    .code_i   (code_q),
    .state_o  (state_next),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '{led_invert_mask: LED_INVERT_RESET,
                   presence_ticks: PRESENCE_TICKS_RESET};
      state_q <= STATE_RESET;
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      cfg_q   <= cfg_d;
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
      if (adv) begin
        state_q <= state_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      func_q <= in_s.func;
      code_q <= in_s.status_code;
    end
    if (adv) begin
      result_q <= result_d;
    end
  end

  assign out_s.valid       = out_v_q;
  assign out_s.led_levels  = result_q.led_levels;
  assign out_s.active_code = result_q.active_code;
  assign out_s.present_ok  = result_q.present_ok;

`ifndef ASSERT_OFF
  a_parked_on_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.parked |-> state_q.shown_code == CODE_RUN)
    else $error("engine parked while not showing run");

  a_latch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.presence_latch <= CODE_LAST)
    else $error("presence latch holds a code that was never shown");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_s.ready |-> (in_v_q && out_v_q && !out_s.ready))
    else $error("input stalled without a full pipeline");

  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_v_q)
    else $error("processed request produced no result");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench for led_status_pattern_sequencer_core: directed then random requests, every
// result compared with an in-bench model of the sequencer
// depends on lsps_pkg, lsps_if and the core
module testbench;
  import lsps_pkg::*;

  typedef struct packed {
    logic [NumCodes-1:0]                  req_mask;
    logic [CodeW-1:0]                     shown;
    logic [CodeW-1:0]                     checked;
    logic [CodeW-1:0]                     latched;
    logic [CountW-1:0]                    ticks;
    logic [SeqCount-1:0][PatternBits-1:0] shifter;
    logic [SeqCount-1:0][PatternBits-1:0] reload;
    logic                                 wake;
    logic                                 parked;
    logic [2:0]                           leds;
  } seq_model_t;

  typedef struct packed {
    func_e            func;
    logic [CodeW-1:0] code;
  } led_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                drv_valid = 1'b0;
  logic [1:0]          drv_func = FUNC_NOP;
  logic [CodeW-1:0]    drv_code = CODE_INVALID;
  logic                rcv_ready = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = CFG_LED_INVERT;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic [2:0]        cfg_invert = LED_INVERT_RESET;
  logic [CountW-1:0] cfg_thr = PRESENCE_TICKS_RESET;
  bit                send_calm = 1'b0;
  bit                recv_calm = 1'b0;

  led_req_t    pending_requests[$];
  result_t     predicted_results[$];
  led_req_t    in_flight;
  seq_model_t  score_model;
  seq_model_t  plan_model;
  int unsigned planned_count;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned hold_left = 0;
  bit          long_hold_done = 1'b0;

  lsps_in_if  req_ch ();
  lsps_out_if res_ch ();

  assign req_ch.valid       = drv_valid;
  assign req_ch.func        = drv_func;
  assign req_ch.status_code = drv_code;
  assign res_ch.ready       = rcv_ready;

  led_status_pattern_sequencer_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_s       (req_ch),
    .out_s      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic seq_model_t fresh_model();
    seq_model_t m;
    m = '0;
    m.wake = 1'b1;
    return m;
  endfunction

  function automatic logic [PatternBits-1:0] blink_pattern(input logic [CodeW-1:0] code,
                                                           input int seq);
    logic [SeqCount-1:0][PatternBits-1:0] p;
    p = '0;
    case (code)
      4'd0, 4'd1: p[1] = 16'h0001;
      4'd2: begin
        p[0] = 16'h000C;
        p[1] = 16'h000A;
        p[2] = 16'h0009;
      end
      4'd4:  p[1] = 16'h0801;
      4'd5:  p[1] = 16'h0805;
      4'd6:  p[1] = 16'h0855;
      4'd7:  p[1] = 16'h0955;
      4'd8:  p[1] = 16'h0003;
      4'd9:  p[0] = 16'h001E;
      4'd10: p[0] = 16'h0006;
      default: p = '0;
    endcase
    return p[seq];
  endfunction

  function automatic result_t sequencer_step(inout seq_model_t m, input led_req_t rq,
                                             input logic [2:0] inv,
                                             input logic [CountW-1:0] thr);
    result_t                r;
    logic [CodeW-1:0]       nxt;
    logic [CodeW-1:0]       c;
    logic [PatternBits-1:0] pat;
    logic [PatternBits-1:0] v;
    r.present_ok = 1'b0;
    case (rq.func)
      FUNC_TICK: if (!m.parked) begin
        nxt = CODE_INVALID;
        for (int k = 0; k < NumCodes; k++) if (m.req_mask[k]) nxt = CodeW'(k);
        if (nxt != m.shown) begin
          m.shown = nxt;
          for (int i = 0; i < SeqCount; i++) begin
            pat = blink_pattern(nxt, i);
            if (pat != m.reload[i]) begin
              m.reload[i]  = pat;
              m.shifter[i] = '0;
            end
          end
          m.ticks = '0;
        end
        for (int i = 0; i < LedCount; i++) m.leds[i] = m.shifter[i][0] ^ inv[i];
        if (m.ticks < thr) begin
          m.ticks = m.ticks + 1'b1;
          if (m.ticks == thr) m.latched = m.shown;
        end
        for (int i = 0; i < SeqCount; i++) begin
          v = m.shifter[i] >> 1;
          if (v <= 1) v = m.reload[i];
          m.shifter[i] = v;
        end
        if (m.shown == CODE_RUN) begin
          if (m.wake) m.wake = 1'b0;
          else m.parked = 1'b1;
        end
      end
      FUNC_WINK: begin
        c = (rq.code == CODE_AUTO) ? m.checked : rq.code;
        if (c <= CODE_LAST) m.req_mask[c] = 1'b1;
        if (m.parked) m.parked = 1'b0;
        else m.wake = 1'b1;
      end
      FUNC_CHECK: begin
        r.present_ok = (m.latched == rq.code);
        m.checked = rq.code;
        if (r.present_ok) begin
          m.latched = CODE_INVALID;
          if (rq.code <= CODE_LAST) m.req_mask[rq.code] = 1'b0;
        end
      end
      default: ;
    endcase
    r.led_levels  = m.leds;
    r.active_code = m.shown;
    return r;
  endfunction

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < 50) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // request sender
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (drv_valid && req_ch.ready)
        predicted_results.push_back(sequencer_step(score_model, in_flight, cfg_invert, cfg_thr));
      if (!drv_valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          drv_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_flight = pending_requests.pop_front();
          drv_func  <= in_flight.func;
          drv_code  <= in_flight.code;
          drv_valid <= 1'b1;
          send_gap  <= pick_gap(send_calm);
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver and checker
  always @(posedge clk or negedge rst_n) begin : result_monitor
    result_t     want;
    int unsigned g;
    if (!rst_n) begin
      rcv_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (res_ch.valid && rcv_ready) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          flag_mismatch("result with nothing predicted");
        end else begin
          want = predicted_results.pop_front();
          if (res_ch.led_levels !== want.led_levels)
            flag_mismatch($sformatf("led_levels %b, want %b", res_ch.led_levels,
                                    want.led_levels));
          if (res_ch.active_code !== want.active_code)
            flag_mismatch($sformatf("active_code %0d, want %0d", res_ch.active_code,
                                    want.active_code));
          if (res_ch.present_ok !== want.present_ok)
            flag_mismatch($sformatf("present_ok %b, want %b", res_ch.present_ok,
                                    want.present_ok));
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rcv_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 300) begin
        // long back-pressure so the input side fills and stalls
        long_hold_done <= 1'b1;
        hold_left      <= 250;
        rcv_ready      <= 1'b0;
      end else begin
        g = ($urandom_range(0, 3) == 0) ? pick_gap(recv_calm) : 0;
        if (g > 0) begin
          hold_left <= g - 1;
          rcv_ready <= 1'b0;
        end else begin
          rcv_ready <= 1'b1;
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    if (idx == CFG_LED_INVERT) cfg_invert = data[2:0];
    else cfg_thr = data[CountW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_request(input func_e f, input logic [CodeW-1:0] c);
    led_req_t rq;
    result_t  unused;
    rq.func = f;
    rq.code = c;
    if (!(f == FUNC_TICK && plan_model.parked)) planned_count++;
    unused = sequencer_step(plan_model, rq, cfg_invert, cfg_thr);
    pending_requests.push_back(rq);
  endtask

  function automatic logic [CodeW-1:0] any_code();
    return CodeW'($urandom_range(0, 15));
  endfunction

  task automatic plan_sequence();
    int unsigned      r;
    logic [CodeW-1:0] c;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      // show a code, often long enough for presence, then check it
      r = $urandom_range(0, 9);
      if (r < 8) c = CodeW'($urandom_range(2, 10));
      else if (r == 8) c = CODE_AUTO;
      else c = any_code();
      queue_request(FUNC_WINK, c);
      repeat ($urandom_range(0, cfg_thr + 4)) begin
        if ($urandom_range(0, 7) == 0) queue_request(FUNC_WINK, any_code());
        queue_request(FUNC_TICK, any_code());
      end
      if ($urandom_range(0, 3) != 0) queue_request(FUNC_CHECK, plan_model.latched);
      else queue_request(FUNC_CHECK, any_code());
    end else if (r < 70) begin
      queue_request(FUNC_WINK, CODE_RUN);
      repeat ($urandom_range(1, 4)) queue_request(FUNC_TICK, any_code());
      queue_request(FUNC_WINK, any_code());
      repeat ($urandom_range(1, 4)) queue_request(FUNC_TICK, any_code());
      if ($urandom_range(0, 1) == 0) queue_request(FUNC_CHECK, plan_model.latched);
    end else if (r < 85) begin
      repeat ($urandom_range(1, 6)) queue_request(func_e'($urandom_range(0, 3)), any_code());
    end else begin
      repeat ($urandom_range(1, 8)) queue_request(FUNC_TICK, any_code());
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || drv_valid || predicted_results.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    logic [2:0]        inv;
    logic [CountW-1:0] thr;
    score_model = fresh_model();
    plan_model  = fresh_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty mask, high codes, auto wink, presence, run wait, nop
    write_reg(CFG_PRESENCE_TICKS, 5'd1);
    queue_request(FUNC_NOP, 4'd15);
    queue_request(FUNC_TICK, CODE_INVALID);
    queue_request(FUNC_CHECK, CODE_INVALID);
    queue_request(FUNC_WINK, 4'd15);
    queue_request(FUNC_CHECK, 4'd11);
    queue_request(FUNC_WINK, CODE_AUTO);
    queue_request(FUNC_WINK, CODE_LAST);
    queue_request(FUNC_TICK, 4'd15);
    queue_request(FUNC_CHECK, CODE_LAST);
    queue_request(FUNC_TICK, CODE_INVALID);
    queue_request(FUNC_WINK, CODE_RUN);
    queue_request(FUNC_TICK, CODE_INVALID);
    queue_request(FUNC_TICK, CODE_INVALID);
    queue_request(FUNC_TICK, CODE_INVALID);
    queue_request(FUNC_WINK, CODE_RUN);
    queue_request(FUNC_TICK, CODE_INVALID);
    queue_request(FUNC_CHECK, CODE_RUN);
    queue_request(FUNC_WINK, 4'd2);
    queue_request(FUNC_TICK, CODE_INVALID);
    queue_request(FUNC_TICK, CODE_INVALID);
    queue_request(FUNC_TICK, CODE_INVALID);
    queue_request(FUNC_CHECK, 4'd2);
    queue_request(FUNC_WINK, CODE_AUTO);
    queue_request(FUNC_TICK, CODE_INVALID);
    queue_request(FUNC_NOP, CODE_INVALID);
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          inv = 3'd0;
          thr = 5'd31;
        end
        1: begin
          inv = 3'd7;
          thr = 5'd1;
        end
        2: begin
          inv = 3'($urandom_range(0, 7));
          thr = 5'd0;
        end
        default: begin
          inv = 3'($urandom_range(0, 7));
          thr = CountW'($urandom_range(1, 31));
        end
      endcase
      write_reg(CFG_LED_INVERT, CfgDataW'(inv));
      write_reg(CFG_PRESENCE_TICKS, CfgDataW'(thr));
      send_calm = (phase % 4 == 3) || (phase == 5);
      recv_calm = (phase % 4 == 3) || (phase == 6);
      planned_count = 0;
      while (planned_count < 200) plan_sequence();
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
